// ===== design/ehdt_pkg.sv =====
package ehdt_pkg;

  localparam int TableDepth = 16;
  localparam int IdBits     = 16;
  localparam int EventBits  = 16;
  localparam int MaxResults = 16;

  // field widths fixed by the port list
  localparam int CmdW    = 3;
  localparam int IdFieldW  = 16;
  localparam int EvFieldW  = 16;
  localparam int StatW   = 8;
  localparam int IdxW    = 4;
  localparam int KindW   = 2;

  // stored widths after masking
  localparam int IdW  = (IdBits < IdFieldW) ? IdBits : IdFieldW;
  localparam int EvW  = (EventBits < EvFieldW) ? EventBits : EvFieldW;
  localparam int KeyW = IdW + EvW;

  localparam int AddrBits = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntBits  = $clog2(TableDepth + 1);
  localparam int CmpW     = (CntBits > IdxW) ? CntBits : IdxW;
  localparam int NBits    = $clog2(MaxResults + 1);

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR    = 3'd0,
    CMD_REGISTER = 3'd1,
    CMD_ENABLE   = 3'd2,
    CMD_DISABLE  = 3'd3,
    CMD_STATUS   = 3'd4,
    CMD_DISPATCH = 3'd5
  } cmd_t;

  typedef enum logic [KindW-1:0] {
    KIND_ACK      = 2'd0,
    KIND_REG      = 2'd1,
    KIND_STATUS   = 2'd2,
    KIND_DISPATCH = 2'd3
  } kind_t;

  localparam logic [StatW-1:0] StatEnabled = 8'd1;

  // table address to the 4-bit result index, masked
  function automatic logic [IdxW-1:0] to_idx(input logic [AddrBits-1:0] a);
    logic [AddrBits+IdxW-1:0] t;
    t = {{IdxW{1'b0}}, a};
    return t[IdxW-1:0];
  endfunction

endpackage

// ===== design/ehdt_if.sv =====
interface ehdt_in_if;
  import ehdt_pkg::*;

  logic                valid;
  logic                ready;
  logic [CmdW-1:0]     command;
  logic [IdFieldW-1:0] handler_id;
  logic [EvFieldW-1:0] event_kind;
  logic [StatW-1:0]    initial_status;
  logic [IdxW-1:0]     entry_index;
  logic                broadcast;

  modport source (output valid, command, handler_id, event_kind, initial_status,
                  entry_index, broadcast, input ready);
  modport sink (input valid, command, handler_id, event_kind, initial_status,
                entry_index, broadcast, output ready);
endinterface

interface ehdt_out_if;
  import ehdt_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] result_kind;
  logic             success;
  logic [IdxW-1:0]  result_index;
  logic [StatW-1:0] status_value;
  logic             last;

  modport source (output valid, result_kind, success, result_index, status_value, last,
                  input ready);
  modport sink (input valid, result_kind, success, result_index, status_value, last,
                output ready);
endinterface

// ===== design/event_handler_dispatch_table.sv =====
// Event handler dispatch table.
// in_if  : one command word per handshake (clear, register, enable, disable,
//          status query, dispatch). Accepted only while the sequencer is idle.
// out_if : result words. Every command gives one word with last set, except a
//          dispatch: one word per enabled match (first only, or up to 16 with
//          broadcast; last on the final one) or a single no-match word.
// Clear, enable, disable, status and unused codes go from accept straight to
// the result state. Register with a nonzero id and dispatch walk the filled
// entries through the table memories, one entry per cycle unless a second
// dispatch hit is waiting for the output; register and first-match dispatch
// stop at the first hit.
// The entries live in two synchronous memories (id/type, status) with
// registered read data; entries at or above the fill count are never read.
// Reset empties the table (fill count to zero) and drops any pending result.
// A stalled receiver holds the output register; the walk pauses when a second
// dispatch hit has no place to go. A new command is taken once the current one
// has loaded its last word into the output register, and not before.
module event_handler_dispatch_table (
  input logic    clk,
  input logic    rst_n,
  ehdt_in_if.sink    in_if,
  ehdt_out_if.source out_if
);
  import ehdt_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FIN} state_t;

  logic [KeyW-1:0]  key_mem  [TableDepth];
  logic [StatW-1:0] stat_mem [TableDepth];

  state_t state_r, state_nxt;
  logic [CmdW-1:0]     cmd_r, cmd_nxt;
  logic [IdW-1:0]      id_r, id_nxt;
  logic [EvW-1:0]      ev_r, ev_nxt;
  logic [StatW-1:0]    init_r, init_nxt;
  logic                bcast_r, bcast_nxt;
  logic                ok_r, ok_nxt;
  logic [CntBits-1:0]  count_r, count_nxt;
  logic [CntBits-1:0]  raddr_r, raddr_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic [AddrBits-1:0] chk_idx_r, chk_idx_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [AddrBits-1:0] pend_idx_r, pend_idx_nxt;
  logic [NBits-1:0]    n_r, n_nxt;

  logic             out_v_r;
  logic [KindW-1:0] out_kind_r;
  logic             out_ok_r;
  logic [IdxW-1:0]  out_idx_r;
  logic [StatW-1:0] out_stat_r;
  logic             out_last_r;

  logic [KeyW-1:0]  key_rd_r;
  logic [StatW-1:0] stat_rd_r;

  logic                ren, key_we, stat_we;
  logic [AddrBits-1:0] rd_addr, wr_addr;
  logic [StatW-1:0]    stat_wdata;

  logic             emit;
  logic [KindW-1:0] e_kind;
  logic             e_ok;
  logic [IdxW-1:0]  e_idx;
  logic [StatW-1:0] e_stat;
  logic             e_last;

  logic                out_free, in_acc, hit, stop, full;
  logic [IdW-1:0]      in_id_m;
  logic [EvW-1:0]      in_ev_m;
  logic [CmpW-1:0]     in_idx_w, count_w;
  logic                in_range;
  logic [AddrBits-1:0] in_addr, count_addr;

  assign out_free   = !out_v_r || out_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc     = in_if.valid && (state_r == ST_IDLE);

  assign in_id_m    = in_if.handler_id[IdW-1:0];
  assign in_ev_m    = in_if.event_kind[EvW-1:0];
  assign in_idx_w   = CmpW'(in_if.entry_index);
  assign count_w    = CmpW'(count_r);
  assign in_range   = in_idx_w < count_w;
  assign in_addr    = in_idx_w[AddrBits-1:0];
  assign count_addr = count_r[AddrBits-1:0];
  assign full       = (count_r == CntBits'(TableDepth));

  always_comb begin
    if (cmd_r == CMD_REGISTER) begin
      hit = chk_v_r && (key_rd_r == {id_r, ev_r});
    end else begin
      hit = chk_v_r && (stat_rd_r == StatEnabled) && (key_rd_r[EvW-1:0] == ev_r);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    id_nxt       = id_r;
    ev_nxt       = ev_r;
    init_nxt     = init_r;
    bcast_nxt    = bcast_r;
    ok_nxt       = ok_r;
    count_nxt    = count_r;
    raddr_nxt    = raddr_r;
    chk_v_nxt    = chk_v_r;
    chk_idx_nxt  = chk_idx_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    n_nxt        = n_r;
    ren          = 1'b0;
    rd_addr      = '0;
    key_we       = 1'b0;
    stat_we      = 1'b0;
    wr_addr      = '0;
    stat_wdata   = '0;
    emit         = 1'b0;
    e_kind       = KIND_ACK;
    e_ok         = 1'b0;
    e_idx        = '0;
    e_stat       = '0;
    e_last       = 1'b1;
    stop         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_if.command;
          id_nxt     = in_id_m;
          ev_nxt     = in_ev_m;
          init_nxt   = in_if.initial_status;
          bcast_nxt  = in_if.broadcast;
          ok_nxt     = in_range;
          raddr_nxt  = '0;
          chk_v_nxt  = 1'b0;
          pend_v_nxt = 1'b0;
          n_nxt      = '0;
          state_nxt  = ST_FIN;
          case (in_if.command)
            CMD_CLEAR: count_nxt = '0;
            CMD_REGISTER: begin
              if (in_id_m != '0) state_nxt = ST_WALK;
            end
            CMD_ENABLE, CMD_DISABLE: begin
              if (in_range) begin
                stat_we    = 1'b1;
                wr_addr    = in_addr;
                stat_wdata = (in_if.command == CMD_ENABLE) ? StatEnabled : '0;
              end
            end
            CMD_STATUS: begin
              if (in_range) begin
                ren     = 1'b1;
                rd_addr = in_addr;
              end
            end
            CMD_DISPATCH: state_nxt = ST_WALK;
            default: ;
          endcase
        end
      end

      ST_WALK: begin
        // a second hit waits until the held one can go out
        if (!(hit && pend_v_r && !out_free)) begin
          if (hit) begin
            if (pend_v_r) begin
              emit   = 1'b1;
              e_kind = KIND_DISPATCH;
              e_ok   = 1'b1;
              e_idx  = to_idx(pend_idx_r);
              e_last = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = chk_idx_r;
            n_nxt        = n_r + 1'b1;
            stop = (cmd_r == CMD_REGISTER) || !bcast_r ||
                   (n_r == NBits'(MaxResults - 1));
          end
          if (stop) begin
            chk_v_nxt = 1'b0;
            state_nxt = ST_FIN;
          end else if (raddr_r < count_r) begin
            ren         = 1'b1;
            rd_addr     = raddr_r[AddrBits-1:0];
            raddr_nxt   = raddr_r + 1'b1;
            chk_v_nxt   = 1'b1;
            chk_idx_nxt = raddr_r[AddrBits-1:0];
          end else begin
            chk_v_nxt = 1'b0;
            state_nxt = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
          case (cmd_r)
            CMD_CLEAR: begin
              e_kind = KIND_ACK;
              e_ok   = 1'b1;
            end
            CMD_REGISTER: begin
              e_kind = KIND_REG;
              if (id_r == '0) begin
                e_ok = 1'b0;
              end else if (pend_v_r) begin
                e_ok  = 1'b1;
                e_idx = to_idx(pend_idx_r);
              end else if (full) begin
                e_ok = 1'b0;
              end else begin
                key_we     = 1'b1;
                stat_we    = 1'b1;
                wr_addr    = count_addr;
                stat_wdata = init_r;
                count_nxt  = count_r + 1'b1;
                e_ok       = 1'b1;
                e_idx      = to_idx(count_addr);
              end
            end
            CMD_ENABLE, CMD_DISABLE: begin
              e_kind = KIND_ACK;
              e_ok   = ok_r;
            end
            CMD_STATUS: begin
              e_kind = KIND_STATUS;
              e_ok   = ok_r;
              e_stat = ok_r ? stat_rd_r : '0;
            end
            CMD_DISPATCH: begin
              e_kind = KIND_DISPATCH;
              e_ok   = pend_v_r;
              e_idx  = pend_v_r ? to_idx(pend_idx_r) : '0;
            end
            default: begin
              e_kind = KIND_ACK;
              e_ok   = 1'b0;
            end
          endcase
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      chk_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      chk_v_r  <= chk_v_nxt;
      pend_v_r <= pend_v_nxt;
      if (emit) begin
        out_v_r    <= 1'b1;
        out_kind_r <= e_kind;
        out_ok_r   <= e_ok;
        out_idx_r  <= e_idx;
        out_stat_r <= e_stat;
        out_last_r <= e_last;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    ev_r       <= ev_nxt;
    init_r     <= init_nxt;
    bcast_r    <= bcast_nxt;
    ok_r       <= ok_nxt;
    raddr_r    <= raddr_nxt;
    chk_idx_r  <= chk_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    n_r        <= n_nxt;
  end

  // table memories: one write and one read port, registered read data
  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_addr] <= {id_r, ev_r};
    if (stat_we) stat_mem[wr_addr] <= stat_wdata;
    if (ren) begin
      key_rd_r  <= key_mem[rd_addr];
      stat_rd_r <= stat_mem[rd_addr];
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.result_kind  = out_kind_r;
  assign out_if.success      = out_ok_r;
  assign out_if.result_index = out_idx_r;
  assign out_if.status_value = out_stat_r;
  assign out_if.last         = out_last_r;

endmodule

// ===== tb/sv/dispatch_table_checker.sv =====
module dispatch_table_checker (
  input  logic clk,
  input  logic rst_n,
  ehdt_in_if   in_mon,
  ehdt_out_if  out_mon,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ehdt_pkg::*;

  typedef struct packed {
    kind_t            kind;
    logic             success;
    logic [IdxW-1:0]  index;
    logic [StatW-1:0] status;
    logic             last;
  } result_word_t;

  // shadow copy of the handler table
  logic [IdW-1:0]   tbl_handler [TableDepth];
  logic [EvW-1:0]   tbl_event   [TableDepth];
  logic [StatW-1:0] tbl_status  [TableDepth];
  int               fill;
  result_word_t     results_due [$];

  function automatic result_word_t make_word(kind_t k, logic ok, int idx,
                                             logic [StatW-1:0] st, logic lst);
    result_word_t w;
    w.kind    = k;
    w.success = ok;
    w.index   = idx[IdxW-1:0];
    w.status  = st;
    w.last    = lst;
    return w;
  endfunction

  task automatic apply_command(input logic [CmdW-1:0] cmd,
                               input logic [IdFieldW-1:0] id,
                               input logic [EvFieldW-1:0] ev,
                               input logic [StatW-1:0] init_st,
                               input logic [IdxW-1:0] idx,
                               input logic bcast);
    logic [IdW-1:0] id_m;
    logic [EvW-1:0] ev_m;
    int             found;
    int             hits [$];
    id_m  = id[IdW-1:0];
    ev_m  = ev[EvW-1:0];
    found = -1;
    case (cmd)
      CMD_CLEAR: begin
        fill = 0;
        for (int i = 0; i < TableDepth; i++) begin
          tbl_handler[i] = '0;
          tbl_event[i]   = '0;
          tbl_status[i]  = '0;
        end
        results_due.push_back(make_word(KIND_ACK, 1'b1, 0, '0, 1'b1));
      end
      CMD_REGISTER: begin
        for (int i = 0; i < fill; i++) begin
          if (found < 0 && tbl_handler[i] == id_m && tbl_event[i] == ev_m) found = i;
        end
        if (id_m == '0) begin
          results_due.push_back(make_word(KIND_REG, 1'b0, 0, '0, 1'b1));
        end else if (found >= 0) begin
          results_due.push_back(make_word(KIND_REG, 1'b1, found, '0, 1'b1));
        end else if (fill >= TableDepth) begin
          results_due.push_back(make_word(KIND_REG, 1'b0, 0, '0, 1'b1));
        end else begin
          tbl_handler[fill] = id_m;
          tbl_event[fill]   = ev_m;
          tbl_status[fill]  = init_st;
          results_due.push_back(make_word(KIND_REG, 1'b1, fill, '0, 1'b1));
          fill++;
        end
      end
      CMD_ENABLE, CMD_DISABLE: begin
        if (int'(idx) >= fill) begin
          results_due.push_back(make_word(KIND_ACK, 1'b0, 0, '0, 1'b1));
        end else begin
          tbl_status[idx] = (cmd == CMD_ENABLE) ? StatEnabled : '0;
          results_due.push_back(make_word(KIND_ACK, 1'b1, 0, '0, 1'b1));
        end
      end
      CMD_STATUS: begin
        if (int'(idx) >= fill)
          results_due.push_back(make_word(KIND_STATUS, 1'b0, 0, '0, 1'b1));
        else
          results_due.push_back(make_word(KIND_STATUS, 1'b1, 0, tbl_status[idx], 1'b1));
      end
      CMD_DISPATCH: begin
        for (int i = 0; i < fill && hits.size() < MaxResults; i++) begin
          if (tbl_status[i] == StatEnabled && tbl_event[i] == ev_m) begin
            hits.push_back(i);
            if (!bcast) break;
          end
        end
        if (hits.size() == 0)
          results_due.push_back(make_word(KIND_DISPATCH, 1'b0, 0, '0, 1'b1));
        foreach (hits[j])
          results_due.push_back(make_word(KIND_DISPATCH, 1'b1, hits[j], '0,
                                          j == hits.size() - 1));
      end
      default: results_due.push_back(make_word(KIND_ACK, 1'b0, 0, '0, 1'b1));
    endcase
  endtask

  always @(posedge clk) begin
    result_word_t got;
    result_word_t want;
    if (!rst_n) begin
      fill       = 0;
      mismatches = 0;
      results_due.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        apply_command(in_mon.command, in_mon.handler_id, in_mon.event_kind,
                      in_mon.initial_status, in_mon.entry_index, in_mon.broadcast);
      if (out_mon.valid && out_mon.ready) begin
        got.kind    = kind_t'(out_mon.result_kind);
        got.success = out_mon.success;
        got.index   = out_mon.result_index;
        got.status  = out_mon.status_value;
        got.last    = out_mon.last;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word kind=%0d ok=%0b idx=%0d stat=%0d last=%0b",
                     $realtime, got.kind, got.success, got.index, got.status, got.last);
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%0t: result mismatch: expected kind=%0d ok=%0b idx=%0d stat=%0d ",
                     $realtime, want.kind, want.success, want.index, want.status);
              $display("last=%0b, got kind=%0d ok=%0b idx=%0d stat=%0d last=%0b",
                       want.last, got.kind, got.success, got.index, got.status, got.last);
            end
          end
        end
      end
    end
    pending = results_due.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ehdt_pkg::*;

  localparam logic [CmdW-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CmdW-1:0] CMD_SPARE_HI = 3'd7;
  localparam int ItemTarget    = 430;
  localparam int HoldAt        = 150;
  localparam int DrainAt       = 300;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 4000;

  logic clk = 1'b1;
  logic rst_n;
  int   mismatches;
  int   pending;
  bit   hold_req = 1'b0;
  int   burst_left = 0;
  int   items = 0;

  logic [IdFieldW-1:0] known_id [$];
  logic [EvFieldW-1:0] known_ev [$];

  ehdt_in_if  in_if ();
  ehdt_out_if out_if ();

  event_handler_dispatch_table DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  dispatch_table_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b0;
    #5 clk = 1'b1;
  end

  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_word(input logic [CmdW-1:0] cmd, input logic [IdFieldW-1:0] id,
                           input logic [EvFieldW-1:0] ev, input logic [StatW-1:0] st,
                           input logic [IdxW-1:0] idx, input logic bc);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_if.valid          <= 1'b1;
    in_if.command        <= cmd;
    in_if.handler_id     <= id;
    in_if.event_kind     <= ev;
    in_if.initial_status <= st;
    in_if.entry_index    <= idx;
    in_if.broadcast      <= bc;
    do @(posedge clk); while (!in_if.ready);
    if (cmd == CMD_CLEAR) begin
      known_id.delete();
      known_ev.delete();
    end else if (cmd == CMD_REGISTER && id != '0) begin
      known_id.push_back(id);
      known_ev.push_back(ev);
    end
    items++;
    if (items == HoldAt) hold_req = 1'b1;
    if (items == DrainAt) drain_results();
  endtask

  function automatic logic [StatW-1:0] pick_status();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return StatEnabled;
    if (r < 15) return '0;
    return StatW'($urandom_range(0, 255));
  endfunction

  // receiver: ready follows a mode (always, random, rotating pattern, sparse) picked anew at random
  initial begin
    int             mode;
    int             mode_left;
    logic [7:0]     pattern;
    logic           rdy;
    mode_left = 0;
    pattern   = 8'hA5;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 64);
        pattern   = 8'($urandom_range(1, 255));
      end
      mode_left--;
      case (mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: begin
          rdy     = pattern[0];
          pattern = {pattern[0], pattern[7:1]};
        end
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
      out_if.ready <= rdy;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WatchdogLimit) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    logic [EvFieldW-1:0] ev_pool [4];
    logic [IdFieldW-1:0] id;
    logic [EvFieldW-1:0] ev;
    logic [IdxW-1:0]     idx;
    logic [CmdW-1:0]     cmd;
    bit                  full;
    int                  scen;
    int                  nreg;
    int                  nops;
    int                  op;
    int                  j;

    in_if.valid          = 1'b0;
    in_if.command        = CMD_CLEAR;
    in_if.handler_id     = '0;
    in_if.event_kind     = '0;
    in_if.initial_status = '0;
    in_if.entry_index    = '0;
    in_if.broadcast      = 1'b0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table: every lookup is out of range
    send_word(CMD_STATUS,   16'h0000, 16'h0000, 8'h00, 4'd0,  1'b0);
    send_word(CMD_ENABLE,   16'h0000, 16'h0000, 8'h00, 4'd0,  1'b0);
    send_word(CMD_DISABLE,  16'hFFFF, 16'hFFFF, 8'hFF, 4'd15, 1'b1);
    send_word(CMD_DISPATCH, 16'h0000, 16'h0000, 8'h00, 4'd0,  1'b1);
    // null handler id is refused
    send_word(CMD_REGISTER, 16'h0000, 16'h1234, 8'h01, 4'd0,  1'b0);
    send_word(CMD_REGISTER, 16'hFFFF, 16'hFFFF, 8'h01, 4'd0,  1'b0);
    send_word(CMD_REGISTER, 16'h0001, 16'h0000, 8'h00, 4'd0,  1'b0);
    send_word(CMD_REGISTER, 16'h0001, 16'hFFFF, 8'hFF, 4'd0,  1'b0);
    // same id and type again: old index back, status untouched
    send_word(CMD_REGISTER, 16'hFFFF, 16'hFFFF, 8'h00, 4'd0,  1'b0);
    send_word(CMD_STATUS,   16'h0000, 16'h0000, 8'h00, 4'd2,  1'b0);
    send_word(CMD_STATUS,   16'h0000, 16'h0000, 8'h00, 4'd3,  1'b0);
    send_word(CMD_DISPATCH, 16'h0000, 16'hFFFF, 8'h00, 4'd0,  1'b0);
    send_word(CMD_ENABLE,   16'h0000, 16'h0000, 8'h00, 4'd2,  1'b0);
    send_word(CMD_DISPATCH, 16'h0000, 16'hFFFF, 8'h00, 4'd0,  1'b1);
    send_word(CMD_DISPATCH, 16'h0000, 16'h0000, 8'h00, 4'd0,  1'b1);
    send_word(CMD_DISABLE,  16'h0000, 16'h0000, 8'h00, 4'd0,  1'b0);
    send_word(CMD_DISPATCH, 16'h0000, 16'hFFFF, 8'h00, 4'd0,  1'b0);
    send_word(CMD_SPARE_LO, 16'hFFFF, 16'hFFFF, 8'hFF, 4'd15, 1'b1);
    send_word(CMD_SPARE_HI, 16'h0000, 16'h0000, 8'h00, 4'd0,  1'b0);
    send_word(CMD_CLEAR,    16'h0000, 16'h0000, 8'h00, 4'd0,  1'b0);
    send_word(CMD_STATUS,   16'h0000, 16'h0000, 8'h00, 4'd0,  1'b0);
    // status other than exactly one does not count as enabled
    send_word(CMD_REGISTER, 16'h8000, 16'h8000, 8'h02, 4'd0,  1'b0);
    send_word(CMD_DISPATCH, 16'h0000, 16'h8000, 8'h00, 4'd0,  1'b1);

    scen = 0;
    while (items < ItemTarget) begin
      if (scen == 0 || $urandom_range(0, 9) < 7)
        send_word(CMD_CLEAR, IdFieldW'($urandom()), EvFieldW'($urandom()),
                  StatW'($urandom()), IdxW'($urandom()), 1'($urandom()));
      full = (scen == 0) || ($urandom_range(0, 3) == 0);
      foreach (ev_pool[p])
        ev_pool[p] = ($urandom_range(0, 5) == 0) ? {EvFieldW{p[0]}} : EvFieldW'($urandom());
      nreg = full ? $urandom_range(16, 18) : $urandom_range(1, 10);
      for (int r = 0; r < nreg; r++) begin
        if (full) begin
          send_word(CMD_REGISTER, IdFieldW'($urandom_range(1, 65535)), ev_pool[0],
                    StatEnabled, IdxW'($urandom()), 1'($urandom()));
        end else begin
          id = ($urandom_range(0, 15) == 0) ? '0 : IdFieldW'($urandom_range(1, 65535));
          send_word(CMD_REGISTER, id, ev_pool[2'($urandom())], pick_status(),
                    IdxW'($urandom()), 1'($urandom()));
        end
      end
      nops = $urandom_range(5, 20);
      for (int k = 0; k < nops; k++) begin
        op = $urandom_range(0, 99);
        if (op < 40) begin
          ev = ($urandom_range(0, 7) == 0) ? EvFieldW'($urandom()) : ev_pool[2'($urandom())];
          send_word(CMD_DISPATCH, IdFieldW'($urandom()), ev, StatW'($urandom()),
                    IdxW'($urandom()), 1'($urandom_range(0, 1)));
        end else if (op < 70) begin
          if (op < 55) cmd = $urandom_range(0, 1) ? CMD_ENABLE : CMD_DISABLE;
          else cmd = CMD_STATUS;
          if (known_id.size() == 0 || $urandom_range(0, 4) == 0) idx = IdxW'($urandom());
          else idx = IdxW'($urandom_range(0, known_id.size()));
          send_word(cmd, IdFieldW'($urandom()), EvFieldW'($urandom()), StatW'($urandom()),
                    idx, 1'($urandom()));
        end else if (op < 90) begin
          if (known_id.size() != 0 && $urandom_range(0, 1)) begin
            j = $urandom_range(0, known_id.size() - 1);
            send_word(CMD_REGISTER, known_id[j], known_ev[j], StatW'($urandom()),
                      IdxW'($urandom()), 1'($urandom()));
          end else begin
            id = ($urandom_range(0, 9) == 0) ? '0 : IdFieldW'($urandom());
            send_word(CMD_REGISTER, id, ev_pool[2'($urandom())], pick_status(),
                      IdxW'($urandom()), 1'($urandom()));
          end
        end else begin
          cmd = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
          send_word(cmd, IdFieldW'($urandom()), EvFieldW'($urandom()), StatW'($urandom()),
                    IdxW'($urandom()), 1'($urandom()));
        end
      end
      scen++;
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
